// ===== sv/gyro_rate_integrator_defines.svh =====
// Assertion macros shared by the gyro rate integrator modules
`ifndef GYRO_RATE_INTEGRATOR_DEFINES_SVH
`define GYRO_RATE_INTEGRATOR_DEFINES_SVH

// same-cycle implication, clocked on clk, off while rst is high
`define GRI_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("gyro rate integrator: assertion failed");

// next-cycle implication, clocked on clk, off while rst is high
`define GRI_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("gyro rate integrator: assertion failed");

`endif

// ===== sv/gri_pkg.sv =====
// Types and constants of the gyro rate integrator
`default_nettype none
package gri_pkg;

  localparam int AXES      = 3;
  localparam int RAW_W     = 16;
  localparam int RATE_W    = 32;
  localparam int ANGLE_W   = 48;
  localparam int DVD_W     = 64;
  localparam int CNT_W     = $clog2(DVD_W + 1);
  localparam int CFG_IDX_W = 2;

  // 0.00875 deg/s per LSB in Q.20 is 229376 / 25
  localparam int RATE_NUM   = 229376;
  localparam int RATE_DEN   = 25;
  localparam int RATE_HALF  = RATE_DEN / 2;
  localparam int USEC       = 1000000;
  localparam int USEC_HALF  = USEC / 2;
  localparam int USEC_W     = 20;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Z = 2'd2;

  typedef logic signed [RAW_W-1:0]   raw_t;
  typedef logic signed [RATE_W-1:0]  rate_t;
  typedef logic signed [ANGLE_W-1:0] angle_t;

  // divider command: start pulse and number of quotient bits to develop
  typedef struct packed {
    logic             start;
    logic [CNT_W-1:0] nbits;
  } div_cmd_t;

endpackage
`default_nettype wire

// ===== sv/gri_div.sv =====
// Bit-serial restoring divider, one quotient bit per cycle
`default_nettype none
`include "gyro_rate_integrator_defines.svh"
module gri_div
  import gri_pkg::*;
#(
  parameter int DIV_W = 20
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire div_cmd_t         cmd,
  input  wire logic [DVD_W-1:0] dividend,
  input  wire logic [DIV_W-1:0] divisor,
  output logic      [DVD_W-1:0] quotient,
  output logic                  done
);

  logic [DVD_W-1:0] dvd;
  logic [DVD_W-1:0] quo;
  logic [DIV_W-1:0] rem;
  logic [DIV_W-1:0] dsr;
  logic [CNT_W-1:0] cnt;
  logic [DIV_W:0]   trial;
  logic [DIV_W:0]   trial_sub;
  logic             fits;
  logic [DIV_W-1:0] rem_next;

  // one restoring step: bring down the next dividend bit, subtract if it fits
  always_comb begin
    trial     = {rem, dvd[DVD_W-1]};
    trial_sub = trial - {1'b0, dsr};
    fits      = (trial >= {1'b0, dsr});
    rem_next  = fits ? trial_sub[DIV_W-1:0] : trial[DIV_W-1:0];
  end

  // step counter and completion pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        cnt <= cmd.nbits;
      end else if (cnt != '0) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  // shift registers for dividend, partial remainder and quotient
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      dvd <= dividend;
      dsr <= divisor;
      rem <= '0;
      quo <= '0;
    end else if (cnt != '0) begin
      dvd <= {dvd[DVD_W-2:0], 1'b0};
      rem <= rem_next;
      quo <= {quo[DVD_W-2:0], fits};
    end
  end

  assign quotient = quo;

  `GRI_ASSERT(a_start_when_idle, cmd.start, cnt == '0)
  `GRI_ASSERT_NXT(a_count_down, (cnt != '0) && !cmd.start, cnt == $past(cnt) - 1'b1)
  `GRI_ASSERT_NXT(a_done_after_last, cnt == CNT_W'(1), done)

endmodule
`default_nettype wire

// ===== sv/gri_seq.sv =====
// Per-axis sequencer: scaling, integration and differentiation over the divider
`default_nettype none
`include "gyro_rate_integrator_defines.svh"
module gri_seq
  import gri_pkg::*;
#(
  parameter int  ELAPSED_BITS = 20,
  localparam int DIV_W        = (ELAPSED_BITS > USEC_W) ? ELAPSED_BITS : USEC_W
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  // input transaction
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire raw_t                    raw_x,
  input  wire raw_t                    raw_y,
  input  wire raw_t                    raw_z,
  input  wire logic [ELAPSED_BITS-1:0] elapsed_us,
  // offset registers
  input  wire rate_t                   offset [AXES],
  // divider
  output div_cmd_t                     div_cmd,
  output logic [DVD_W-1:0]             div_dividend,
  output logic [DIV_W-1:0]             div_divisor,
  input  wire logic [DVD_W-1:0]        div_quotient,
  input  wire logic                    div_done,
  // finished result
  output logic                         res_valid,
  input  wire logic                    res_ready,
  output rate_t                        res_rate [AXES],
  output angle_t                       res_angle [AXES],
  output angle_t                       res_accel [AXES],
  output logic                         res_invalid
);

  // quotient lengths: scaled rate, angle step, acceleration
  localparam int SC_BITS = 33;
  localparam int DL_BITS = RATE_W - 1 + ELAPSED_BITS;
  localparam int AC_BITS = 52;
  localparam int SAT_W   = AC_BITS + 1;
  localparam int AXIS_W  = 2;
  localparam logic [AXIS_W-1:0] AXIS_LAST = AXIS_W'(AXES - 1);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_SC_GO   = 4'd1;
  localparam logic [3:0] S_SC_WAIT = 4'd2;
  localparam logic [3:0] S_RATE    = 4'd3;
  localparam logic [3:0] S_MUL     = 4'd4;
  localparam logic [3:0] S_DL_GO   = 4'd5;
  localparam logic [3:0] S_DL_WAIT = 4'd6;
  localparam logic [3:0] S_ANGLE   = 4'd7;
  localparam logic [3:0] S_AC_GO   = 4'd8;
  localparam logic [3:0] S_AC_WAIT = 4'd9;
  localparam logic [3:0] S_ACCEL   = 4'd10;
  localparam logic [3:0] S_DONE    = 4'd11;

  function automatic rate_t sat_rate(input logic [RATE_W:0] v);
    rate_t r;
    if (v[RATE_W] != v[RATE_W-1]) begin
      r = v[RATE_W] ? {1'b1, {(RATE_W-1){1'b0}}} : {1'b0, {(RATE_W-1){1'b1}}};
    end else begin
      r = v[RATE_W-1:0];
    end
    return r;
  endfunction

  function automatic angle_t sat_angle(input logic [SAT_W-1:0] v);
    angle_t r;
    logic   in_range;
    in_range = (&v[SAT_W-1:ANGLE_W-1]) || !(|v[SAT_W-1:ANGLE_W-1]);
    if (!in_range) begin
      r = v[SAT_W-1] ? {1'b1, {(ANGLE_W-1){1'b0}}} : {1'b0, {(ANGLE_W-1){1'b1}}};
    end else begin
      r = v[ANGLE_W-1:0];
    end
    return r;
  endfunction

  logic [3:0]              state;
  logic [AXIS_W-1:0]       axis;
  raw_t                    raw_r [AXES];
  logic [ELAPSED_BITS-1:0] dt;
  rate_t                   prev [AXES];
  angle_t                  acc [AXES];
  angle_t                  accel [AXES];
  rate_t                   rate_cur;
  logic [DVD_W-1:0]        prod;
  logic                    neg;

  logic [RAW_W-1:0]             raw_sel;
  logic                         raw_neg;
  logic [RAW_W:0]               raw_mag;
  logic [SC_BITS:0]             scale_num;
  logic [RATE_W:0]              q_sc;
  logic [RATE_W:0]              scaled;
  logic [RATE_W-1:0]            offset_sel;
  logic [RATE_W:0]              rate_sum;
  logic [RATE_W-1:0]            rc;
  logic [RATE_W-1:0]            rate_mag;
  logic [RATE_W+ELAPSED_BITS-1:0] mul_rd;
  logic [DVD_W-1:0]             dl_sum;
  logic [ANGLE_W:0]             q_dl;
  logic [ANGLE_W:0]             delta;
  logic [ANGLE_W-1:0]           acc_sel;
  logic [ANGLE_W:0]             ang_sum;
  logic [RATE_W-1:0]            ps;
  logic [RATE_W:0]              diff;
  logic [RATE_W:0]              diff_neg;
  logic [RATE_W-1:0]            diff_mag;
  logic [AC_BITS-1:0]           mul_df;
  logic [DVD_W-1:0]             ac_sum;
  logic [AC_BITS:0]             q_ac;
  logic [AC_BITS:0]             accel_s;
  logic                         dt_zero;

  // rate scaling operands
  always_comb begin
    raw_sel   = raw_r[axis];
    raw_neg   = raw_sel[RAW_W-1];
    raw_mag   = raw_neg ? ((RAW_W+1)'(0) - {raw_sel[RAW_W-1], raw_sel}) : {1'b0, raw_sel};
    scale_num = (SC_BITS+1)'(raw_mag) * (SC_BITS+1)'(RATE_NUM) + (SC_BITS+1)'(RATE_HALF);
    q_sc      = div_quotient[RATE_W:0];
    scaled    = neg ? ((RATE_W+1)'(0) - q_sc) : q_sc;
    offset_sel = offset[axis];
    rate_sum  = scaled + {offset_sel[RATE_W-1], offset_sel};
  end

  // angle step operands
  always_comb begin
    rc       = rate_cur;
    rate_mag = rc[RATE_W-1] ? (RATE_W'(0) - rc) : rc;
    mul_rd   = (RATE_W+ELAPSED_BITS)'(rate_mag) * (RATE_W+ELAPSED_BITS)'(dt);
    dl_sum   = prod + DVD_W'(USEC_HALF);
    q_dl     = div_quotient[ANGLE_W:0];
    delta    = neg ? ((ANGLE_W+1)'(0) - q_dl) : q_dl;
    acc_sel  = acc[axis];
    ang_sum  = {acc_sel[ANGLE_W-1], acc_sel} + delta;
  end

  // acceleration operands
  always_comb begin
    ps       = prev[axis];
    diff     = {rc[RATE_W-1], rc} - {ps[RATE_W-1], ps};
    diff_neg = (RATE_W+1)'(0) - diff;
    diff_mag = diff[RATE_W] ? diff_neg[RATE_W-1:0] : diff[RATE_W-1:0];
    mul_df   = AC_BITS'(diff_mag) * AC_BITS'(USEC);
    ac_sum   = prod + DVD_W'(dt >> 1);
    q_ac     = div_quotient[AC_BITS:0];
    accel_s  = neg ? ((AC_BITS+1)'(0) - q_ac) : q_ac;
    dt_zero  = (dt == '0);
  end

  // divider command, dividend left-aligned to the quotient length
  always_comb begin
    unique case (state)
      S_SC_GO: begin
        div_cmd.start = 1'b1;
        div_cmd.nbits = CNT_W'(SC_BITS);
        div_dividend  = {scale_num[SC_BITS-1:0], {(DVD_W-SC_BITS){1'b0}}};
        div_divisor   = DIV_W'(RATE_DEN);
      end
      S_DL_GO: begin
        div_cmd.start = 1'b1;
        div_cmd.nbits = CNT_W'(DL_BITS);
        div_dividend  = {dl_sum[DL_BITS-1:0], {(DVD_W-DL_BITS){1'b0}}};
        div_divisor   = DIV_W'(USEC);
      end
      S_AC_GO: begin
        div_cmd.start = 1'b1;
        div_cmd.nbits = CNT_W'(AC_BITS);
        div_dividend  = {ac_sum[AC_BITS-1:0], {(DVD_W-AC_BITS){1'b0}}};
        div_divisor   = DIV_W'(dt);
      end
      default: begin
        div_cmd.start = 1'b0;
        div_cmd.nbits = '0;
        div_dividend  = '0;
        div_divisor   = '0;
      end
    endcase
  end

  // control and state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      axis  <= '0;
      for (int i = 0; i < AXES; i++) begin
        prev[i] <= '0;
        acc[i]  <= '0;
      end
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            axis  <= '0;
            state <= S_SC_GO;
          end
        end
        S_SC_GO:   state <= S_SC_WAIT;
        S_SC_WAIT: if (div_done) state <= S_RATE;
        S_RATE:    state <= S_MUL;
        S_MUL:     state <= S_DL_GO;
        S_DL_GO:   state <= S_DL_WAIT;
        S_DL_WAIT: if (div_done) state <= S_ANGLE;
        S_ANGLE: begin
          acc[axis] <= sat_angle({{(SAT_W-ANGLE_W-1){ang_sum[ANGLE_W]}}, ang_sum});
          state     <= dt_zero ? S_ACCEL : S_AC_GO;
        end
        S_AC_GO:   state <= S_AC_WAIT;
        S_AC_WAIT: if (div_done) state <= S_ACCEL;
        S_ACCEL: begin
          prev[axis] <= rate_cur;
          if (axis == AXIS_LAST) begin
            axis  <= '0;
            state <= S_DONE;
          end else begin
            axis  <= axis + 1'b1;
            state <= S_SC_GO;
          end
        end
        S_DONE:    if (res_ready) state <= S_IDLE;
        default:   state <= S_IDLE;
      endcase
    end
  end

  // working payload
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        raw_r[0] <= raw_x;
        raw_r[1] <= raw_y;
        raw_r[2] <= raw_z;
        dt       <= elapsed_us;
      end
      S_SC_GO: neg <= raw_neg;
      S_RATE:  rate_cur <= sat_rate(rate_sum);
      S_MUL: begin
        prod <= DVD_W'(mul_rd);
        neg  <= rc[RATE_W-1];
      end
      S_ANGLE: begin
        prod <= DVD_W'(mul_df);
        neg  <= diff[RATE_W];
      end
      S_ACCEL: accel[axis] <= dt_zero ? '0 : sat_angle(accel_s);
      default: ;
    endcase
  end

  assign in_ready    = (state == S_IDLE);
  assign res_valid   = (state == S_DONE);
  assign res_rate    = prev;
  assign res_angle   = acc;
  assign res_accel   = accel;
  assign res_invalid = dt_zero;

  `GRI_ASSERT(a_done_in_wait, div_done,
              (state == S_SC_WAIT) || (state == S_DL_WAIT) || (state == S_AC_WAIT))
  `GRI_ASSERT(a_axis_range, state != S_IDLE, axis <= AXIS_LAST)
  `GRI_ASSERT_NXT(a_accept_starts, in_valid && in_ready, (state == S_SC_GO) && (axis == '0))

endmodule
`default_nettype wire

// ===== sv/gyro_rate_integrator.sv =====
// Gyro rate integrator: three-axis rate, angle and angular acceleration
// One transaction at a time: a new input is taken only when the sequencer is idle again
// after all three axes; the acceleration division is skipped when elapsed_us is zero.
// The single bit-serial divider sets the pace; it develops 33 + (31 + ELAPSED_BITS) + 52
// quotient bits per axis, or 33 + (31 + ELAPSED_BITS) when elapsed_us is zero.
// Reset (rst, synchronous): offsets, previous rates and angle accumulators clear to zero.
`default_nettype none
module gyro_rate_integrator
  import gri_pkg::*;
#(
  parameter int ELAPSED_BITS = 20
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  // configuration
  input  wire logic                    cfg_write,
  input  wire logic [CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [RATE_W-1:0]       cfg_data,
  // input channel
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire raw_t                    raw_x,
  input  wire raw_t                    raw_y,
  input  wire raw_t                    raw_z,
  input  wire logic [ELAPSED_BITS-1:0] elapsed_us,
  // output channel
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output rate_t                        rate_x,
  output rate_t                        rate_y,
  output rate_t                        rate_z,
  output angle_t                       angle_x,
  output angle_t                       angle_y,
  output angle_t                       angle_z,
  output angle_t                       accel_x,
  output angle_t                       accel_y,
  output angle_t                       accel_z,
  output logic                         accel_invalid
);

  localparam int DIV_W = (ELAPSED_BITS > USEC_W) ? ELAPSED_BITS : USEC_W;

  rate_t            offset [AXES];
  div_cmd_t         div_cmd;
  logic [DVD_W-1:0] div_dividend;
  logic [DIV_W-1:0] div_divisor;
  logic [DVD_W-1:0] div_quotient;
  logic             div_done;
  logic             res_valid;
  logic             res_ready;
  rate_t            res_rate [AXES];
  angle_t           res_angle [AXES];
  angle_t           res_accel [AXES];
  logic             res_invalid;
  logic             load;

  // offset registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < AXES; i++) begin
        offset[i] <= '0;
      end
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_OFFSET_X: offset[0] <= cfg_data;
        REG_OFFSET_Y: offset[1] <= cfg_data;
        REG_OFFSET_Z: offset[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  gri_seq #(
    .ELAPSED_BITS (ELAPSED_BITS)
  ) u_seq (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .raw_x        (raw_x),
    .raw_y        (raw_y),
    .raw_z        (raw_z),
    .elapsed_us   (elapsed_us),
    .offset       (offset),
    .div_cmd      (div_cmd),
    .div_dividend (div_dividend),
    .div_divisor  (div_divisor),
    .div_quotient (div_quotient),
    .div_done     (div_done),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .res_rate     (res_rate),
    .res_angle    (res_angle),
    .res_accel    (res_accel),
    .res_invalid  (res_invalid)
  );

  gri_div #(
    .DIV_W (DIV_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .cmd      (div_cmd),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_quotient),
    .done     (div_done)
  );

  // output register, frees the sequencer while a result waits
  assign res_ready = !out_valid || out_ready;
  assign load      = res_valid && res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rate_x        <= res_rate[0];
      rate_y        <= res_rate[1];
      rate_z        <= res_rate[2];
      angle_x       <= res_angle[0];
      angle_y       <= res_angle[1];
      angle_z       <= res_angle[2];
      accel_x       <= res_accel[0];
      accel_y       <= res_accel[1];
      accel_z       <= res_accel[2];
      accel_invalid <= res_invalid;
    end
  end

endmodule
`default_nettype wire
